// ===== design/camera_frustum_point_filter_macros.svh =====
// assertion macros for the camera frustum point filter
// used by the top level only, no other dependencies
`ifndef CAMERA_FRUSTUM_POINT_FILTER_MACROS_SVH
`define CAMERA_FRUSTUM_POINT_FILTER_MACROS_SVH

// property must hold on every clock edge outside reset
`define CFPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication: consequent checked in the cycle after the antecedent
`define CFPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cfpf_pkg.sv =====
// types and constants for the camera frustum point filter
// no dependencies
package cfpf_pkg;

   localparam int unsigned CoefCount = 24;
   localparam int unsigned CoefIdxW  = 5;
   localparam int unsigned SizeW     = 14;
   localparam int unsigned CsrAddrW  = 2;
   localparam int unsigned CsrDataW  = 14;
   localparam int unsigned QW        = 48;

   localparam logic [CsrAddrW-1:0] CSR_FOV_ENABLE   = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic MODE_COEF  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   localparam logic [SizeW-1:0] WIDTH_RESET  = 14'd1242;
   localparam logic [SizeW-1:0] HEIGHT_RESET = 14'd375;

   typedef struct packed {
      logic                       mode;
      logic [CoefIdxW-1:0]        coef_index;
      logic signed [31:0]         coef_value;
      logic signed [31:0]         point_x;
      logic signed [31:0]         point_y;
      logic signed [31:0]         point_z;
      logic [31:0]                point_intensity;
      logic [23:0]                point_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0]         out_x;
      logic signed [31:0]         out_y;
      logic signed [31:0]         out_z;
      logic [31:0]                out_intensity;
      logic [23:0]                out_index;
   } rsp_type;

endpackage

// ===== design/camera_frustum_point_filter.sv =====
// camera frustum point filter, top level
// depends on cfpf_pkg and camera_frustum_point_filter_macros.svh
//
//   channel | ports             | direction | carries
//   req     | req_valid/ready   | in        | coefficient load or lidar point
//   rsp     | rsp_valid/ready   | out       | kept point
//   csr     | csr_we/addr/wdata | in        | enable, image width, image height
//
// one point transaction per cycle sustained while rsp is not stalled; a point passes
// from acceptance to the result register through the two multiply stages, two sum stages,
// the bound multiply, the compare stage and the output register
// a coefficient load waits while a point sits in the first two stages
// reset clears valid bits and configuration registers; the coefficient table is not cleared
// a stall on rsp freezes the whole pipeline, so nothing is lost or repeated
`include "camera_frustum_point_filter_macros.svh"

module camera_frustum_point_filter #(
   parameter int FRAC_BITS   = 16,
   parameter int INDEX_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cfpf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cfpf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [cfpf_pkg::CsrAddrW-1:0]       csr_addr,
   input  logic [cfpf_pkg::CsrDataW-1:0]       csr_wdata
);

   localparam int Stages = 7;
   localparam int PW     = 64 - FRAC_BITS;   // shifted product width
   localparam int QW     = cfpf_pkg::QW;

   // configuration
   logic                           fov_enable_ff;
   logic [cfpf_pkg::SizeW-1:0]     image_width_ff, image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_enable_ff   <= 1'b0;
         image_width_ff  <= cfpf_pkg::WIDTH_RESET;
         image_height_ff <= cfpf_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            cfpf_pkg::CSR_FOV_ENABLE:   fov_enable_ff   <= csr_wdata[0];
            cfpf_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            cfpf_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coefficient registers, each read at a fixed place
   logic signed [31:0] coef_ff [cfpf_pkg::CoefCount];

   // pipeline advance: whole pipe moves unless the output is held
   logic adv;
   assign adv = !rsp_valid || rsp_ready;

   // valid bits and point payload travel together
   logic               vld_ff [Stages];
   cfpf_pkg::rsp_type  pay_ff [Stages];

   // points in the first two stages still read the table later on
   logic coef_hazard;
   assign coef_hazard = vld_ff[0] || vld_ff[1];
   assign req_ready   = adv && !(req_data.mode == cfpf_pkg::MODE_COEF && coef_hazard);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_fire && req_data.mode == cfpf_pkg::MODE_COEF &&
          req_data.coef_index < cfpf_pkg::CoefIdxW'(cfpf_pkg::CoefCount)) begin
         coef_ff[req_data.coef_index] <= req_data.coef_value;
      end
   end

   // stage 1: transform products
   logic signed [63:0] tp_ff [3][3];
   // stage 2: camera coordinates, saturated
   logic signed [31:0] cam_ff [3];
   // stage 3: projection products
   logic signed [63:0] pp_ff [3][3];
   // stage 4: projection sums, saturated
   logic signed [QW-1:0] q_ff [3];
   // stage 5: bounds
   logic signed [QW+15:0] bw_ff, bh_ff;
   logic signed [QW-1:0]  q0_ff, q1_ff, w_ff;
   logic                  cam_ok_ff;
   logic                  cam_ok4_ff, cam_ok5_ff;
   // stage 6: keep decision
   logic                  keep_ff;

   logic signed [31:0] cam_in [3];
   logic signed [QW-1:0] q_in [3];
   logic signed [PW+2:0] tsum, psum;
   logic signed [63:0] pt [3];

   always_comb begin
      pt[0] = 64'(req_data.point_x);
      pt[1] = 64'(req_data.point_y);
      pt[2] = 64'(req_data.point_z);
      for (int r = 0; r < 3; r++) begin
         tsum = (PW+3)'(tp_ff[r][0] >>> FRAC_BITS) + (PW+3)'(tp_ff[r][1] >>> FRAC_BITS)
              + (PW+3)'(tp_ff[r][2] >>> FRAC_BITS) + (PW+3)'(coef_ff[r*4+3]);
         if (tsum > (PW+3)'(64'sh7FFFFFFF))       cam_in[r] = 32'sh7FFFFFFF;
         else if (tsum < -(PW+3)'(64'sh80000000)) cam_in[r] = 32'sh80000000;
         else                                       cam_in[r] = 32'(tsum);
         psum = (PW+3)'(pp_ff[r][0] >>> FRAC_BITS) + (PW+3)'(pp_ff[r][1] >>> FRAC_BITS)
              + (PW+3)'(pp_ff[r][2] >>> FRAC_BITS) + (PW+3)'(coef_ff[12+r*4+3]);
         if (psum > (PW+3)'(64'sh7FFFFFFFFFFF))       q_in[r] = {1'b0, {(QW-1){1'b1}}};
         else if (psum < -(PW+3)'(64'sh800000000000)) q_in[r] = {1'b1, {(QW-1){1'b0}}};
         else                                           q_in[r] = QW'(psum);
      end
   end

   // range checks, sign-aware, after cross multiplication
   logic ok_u, ok_v;
   always_comb begin
      if (w_ff > 0) begin
         ok_u = (q0_ff >= 0) && ((QW+16)'(q0_ff) < bw_ff);
         ok_v = (q1_ff >= 0) && ((QW+16)'(q1_ff) < bh_ff);
      end else begin
         ok_u = (q0_ff <= 0) && ((QW+16)'(q0_ff) > bw_ff);
         ok_v = (q1_ff <= 0) && ((QW+16)'(q1_ff) > bh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Stages; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_fire && req_data.mode == cfpf_pkg::MODE_POINT;
         for (int s = 1; s < Stages - 1; s++) vld_ff[s] <= vld_ff[s-1];
         vld_ff[Stages-1] <= vld_ff[Stages-2] && (!fov_enable_ff || keep_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay_ff[0].out_x         <= req_data.point_x;
         pay_ff[0].out_y         <= req_data.point_y;
         pay_ff[0].out_z         <= req_data.point_z;
         pay_ff[0].out_intensity <= req_data.point_intensity;
         pay_ff[0].out_index     <= 24'(req_data.point_index[INDEX_WIDTH > 24 ? 23 :
                                          INDEX_WIDTH-1:0]);
         for (int s = 1; s < Stages; s++) pay_ff[s] <= pay_ff[s-1];
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               tp_ff[r][k] <= 64'(coef_ff[r*4+k]) * pt[k];
               pp_ff[r][k] <= 64'(coef_ff[12+r*4+k]) * 64'(cam_ff[k]);
            end
            cam_ff[r] <= cam_in[r];
            q_ff[r]   <= q_in[r];
         end
         cam_ok_ff  <= cam_ff[2] > 0;
         cam_ok4_ff <= cam_ok_ff;
         q0_ff <= q_ff[0];
         q1_ff <= q_ff[1];
         w_ff  <= q_ff[2];
         bw_ff <= (QW+16)'(q_ff[2]) * (QW+16)'({1'b0, image_width_ff});
         bh_ff <= (QW+16)'(q_ff[2]) * (QW+16)'({1'b0, image_height_ff});
         cam_ok5_ff <= cam_ok4_ff;
         keep_ff <= cam_ok5_ff && (w_ff != 0) && ok_u && ok_v;
      end
   end

   assign rsp_valid = vld_ff[Stages-1];
   assign rsp_data  = pay_ff[Stages-1];

   `CFPF_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "held result changed")
   `CFPF_ASSERT(a_ready, clock, reset, !req_ready || !rsp_valid || rsp_ready, "ready high during output stall")
   `CFPF_ASSERT_NEXT(a_coef, clock, reset, req_valid && req_ready && req_data.mode == cfpf_pkg::MODE_COEF, !vld_ff[0], "coefficient load entered pipe")

endmodule

// ===== bench/camera_frustum_point_filter_tb.sv =====
// testbench for the camera frustum point filter: coefficient loads and lidar points
// in, kept points out, checked against an in-bench fixed-point visibility predictor
// depends on cfpf_pkg and the camera_frustum_point_filter top level
module camera_frustum_point_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC      = 16;
   localparam int Q_ONE     = 65536;
   localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint Q48_MIN = -Q48_MAX - 1;

   // coefficient sets used by the phases
   typedef enum int {COEFS_PINHOLE, COEFS_MIRRORED, COEFS_FLAT_W, COEFS_RANDOM} coef_set_type;

   // scoreboard: mirrors the table and registers, holds the kept points still owed
   class filter_scoreboard;
      logic [31:0]                coef_table [cfpf_pkg::CoefCount];
      bit                         fov_en;
      logic [cfpf_pkg::SizeW-1:0] img_w;
      logic [cfpf_pkg::SizeW-1:0] img_h;
      cfpf_pkg::rsp_type          kept_points [$];
      int                         errors;

      function new();
         fov_en = 1'b0;
         img_w  = cfpf_pkg::WIDTH_RESET;
         img_h  = cfpf_pkg::HEIGHT_RESET;
         errors = 0;
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function longint sat(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // one matrix row applied to (a, b, c, 1), each product floored by the shift
      function longint row_sum(int base, longint a, longint b, longint c);
         longint acc;
         acc = ((longint'($signed(coef_table[base]))     * a) >>> FRAC)
             + ((longint'($signed(coef_table[base + 1])) * b) >>> FRAC)
             + ((longint'($signed(coef_table[base + 2])) * c) >>> FRAC);
         return acc + longint'($signed(coef_table[base + 3]));
      endfunction

      function bit in_bounds(longint num, longint w, logic [cfpf_pkg::SizeW-1:0] limit);
         longint bound;
         bound = longint'({50'd0, limit}) * w;
         if (w > 0) return num >= 0 && num < bound;
         return num <= 0 && num > bound;
      endfunction

      function bit lands_in_image(longint px, longint py, longint pz);
         longint cam [3];
         longint q [3];
         for (int r = 0; r < 3; r++)
            cam[r] = sat(row_sum(r * 4, px, py, pz), -64'sd2147483648, 64'sd2147483647);
         if (cam[2] <= 0) return 1'b0;
         for (int r = 0; r < 3; r++)
            q[r] = sat(row_sum(12 + r * 4, cam[0], cam[1], cam[2]), Q48_MIN, Q48_MAX);
         if (q[2] == 0) return 1'b0;
         return in_bounds(q[0], q[2], img_w) && in_bounds(q[1], q[2], img_h);
      endfunction

      function void note_request(cfpf_pkg::req_type r);
         cfpf_pkg::rsp_type p;
         if (r.mode == cfpf_pkg::MODE_COEF) begin
            if (r.coef_index < cfpf_pkg::CoefCount) coef_table[r.coef_index] = r.coef_value;
            return;
         end
         if (fov_en && !lands_in_image(r.point_x, r.point_y, r.point_z)) return;
         p.out_x         = r.point_x;
         p.out_y         = r.point_y;
         p.out_z         = r.point_z;
         p.out_intensity = r.point_intensity;
         p.out_index     = r.point_index;
         kept_points = {kept_points, p};
      endfunction

      task check_result(cfpf_pkg::rsp_type r);
         cfpf_pkg::rsp_type e;
         if (kept_points.size() == 0) begin
            report_mismatch($sformatf("unexpected point, index %0h", r.out_index));
            return;
         end
         e = kept_points.pop_front();
         if (r.out_x !== e.out_x)
            report_mismatch($sformatf("x got %0h want %0h", r.out_x, e.out_x));
         if (r.out_y !== e.out_y)
            report_mismatch($sformatf("y got %0h want %0h", r.out_y, e.out_y));
         if (r.out_z !== e.out_z)
            report_mismatch($sformatf("z got %0h want %0h", r.out_z, e.out_z));
         if (r.out_intensity !== e.out_intensity)
            report_mismatch($sformatf("intensity got %0h want %0h",
                                      r.out_intensity, e.out_intensity));
         if (r.out_index !== e.out_index)
            report_mismatch($sformatf("index got %0h want %0h", r.out_index, e.out_index));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   cfpf_pkg::req_type             req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   cfpf_pkg::rsp_type             rsp_data;
   logic                          csr_we;
   logic [cfpf_pkg::CsrAddrW-1:0] csr_addr;
   logic [cfpf_pkg::CsrDataW-1:0] csr_wdata;

   filter_scoreboard sb;
   bit               no_gaps;       // stretch with neither side idling
   int               hold_cycles;   // long receiver hold-off, counted down below
   int               rsp_wait;

   camera_frustum_point_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard limit, far beyond the slowest legal run
   initial begin
      #8ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random hold-off per transaction, plus the occasional long hold
   initial begin
      rsp_ready = 1'b0;
      rsp_wait  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(rsp_data);
            rsp_wait = no_gaps ? 0 : $urandom_range(0, 18);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one transaction and hold it until accepted
   task send_item(cfpf_pkg::req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   // sender pause until every owed point is out, then drain the pipe
   task wait_idle();
      req_valid <= 1'b0;
      while (sb.kept_points.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task write_csr(logic [cfpf_pkg::CsrAddrW-1:0] addr, logic [cfpf_pkg::CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (addr)
         cfpf_pkg::CSR_FOV_ENABLE:   sb.fov_en = data[0];
         cfpf_pkg::CSR_IMAGE_WIDTH:  sb.img_w  = data[cfpf_pkg::SizeW-1:0];
         cfpf_pkg::CSR_IMAGE_HEIGHT: sb.img_h  = data[cfpf_pkg::SizeW-1:0];
         default: ;
      endcase
   endtask

   function automatic cfpf_pkg::req_type random_fields();
      cfpf_pkg::req_type r;
      r.mode            = 1'($urandom_range(0, 1));
      r.coef_index      = 5'($urandom_range(0, 31));
      r.coef_value      = $urandom;
      r.point_x         = $urandom;
      r.point_y         = $urandom;
      r.point_z         = $urandom;
      r.point_intensity = $urandom;
      r.point_index     = 24'($urandom);
      return r;
   endfunction

   function automatic cfpf_pkg::req_type make_point(int x, int y, int z);
      cfpf_pkg::req_type r;
      r         = random_fields();
      r.mode    = cfpf_pkg::MODE_POINT;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      return r;
   endfunction

   // lidar-like point: mostly ahead of the sensor, some behind
   function automatic cfpf_pkg::req_type scene_point();
      return make_point(int'($urandom_range(0, 70 << 16)) - (10 << 16),
                        int'($urandom_range(0, 60 << 16)) - (30 << 16),
                        int'($urandom_range(0, 20 << 16)) - (10 << 16));
   endfunction

   // lidar axes to camera axes, then a pinhole for a 1242 x 375 image, varied by kind
   task load_coefs(coef_set_type kind);
      int                vals [cfpf_pkg::CoefCount];
      cfpf_pkg::req_type r;
      vals = '{0, -Q_ONE, 0, 0,   0, 0, -Q_ONE, 0,   Q_ONE, 0, 0, 0,
               700 * Q_ONE, 0, 621 * Q_ONE, 0,   0, 700 * Q_ONE, 187 * Q_ONE, 0,
               0, 0, Q_ONE, 0};
      case (kind)
         COEFS_MIRRORED: for (int i = 12; i < cfpf_pkg::CoefCount; i++) vals[i] = -vals[i];
         COEFS_FLAT_W:   for (int i = 20; i < cfpf_pkg::CoefCount; i++) vals[i] = 0;
         COEFS_RANDOM:   for (int i = 0; i < cfpf_pkg::CoefCount; i++) vals[i] = $urandom;
         default: ;
      endcase
      for (int i = 0; i < cfpf_pkg::CoefCount; i++) begin
         r            = random_fields();
         r.mode       = cfpf_pkg::MODE_COEF;
         r.coef_index = 5'(i);
         r.coef_value = vals[i];
         send_item(r);
      end
   endtask

   function automatic logic [cfpf_pkg::SizeW-1:0] pick_size();
      case ($urandom_range(0, 6))
         0: return 14'd0;
         1: return 14'd1;
         2: return 14'd8192;
         3: return 14'd16383;
         4: return 14'($urandom_range(0, 16383));
         default: return 14'($urandom_range(200, 2000));
      endcase
   endfunction

   initial begin
      cfpf_pkg::req_type r;
      int                n;
      sb          = new();
      no_gaps     = 1'b0;
      hold_cycles = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_addr    = cfpf_pkg::CSR_FOV_ENABLE;
      csr_wdata   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the table first, nothing is read unwritten
      load_coefs(COEFS_PINHOLE);
      // check off after reset: extremes pass untouched
      send_item(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0));
      send_item(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, -1));
      r = make_point(0, 0, 0);
      r.point_intensity = '1;
      r.point_index     = '1;
      send_item(r);
      r.point_intensity = '0;
      r.point_index     = '0;
      send_item(r);
      // ignored coefficient indexes above the table
      r = random_fields();
      r.mode = cfpf_pkg::MODE_COEF;
      r.coef_index = 5'd31;
      send_item(r);
      r.coef_index = 5'd24;
      send_item(r);
      wait_idle();

      write_csr(cfpf_pkg::CSR_FOV_ENABLE, 14'h3FFF);
      send_item(make_point(10 << 16, 0, 0));           // straight ahead, kept
      send_item(make_point(-(10 << 16), 0, 0));        // behind the camera
      send_item(make_point(0, 0, 0));                  // zero depth
      send_item(make_point(10 << 16, 20 << 16, 0));    // off the left edge
      send_item(make_point(10 << 16, 0, 5 << 16));     // above the image
      send_item(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
      send_item(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      wait_idle();

      // zero image size drops all while enabled
      write_csr(cfpf_pkg::CSR_IMAGE_WIDTH, 14'd0);
      send_item(make_point(10 << 16, 0, 0));
      wait_idle();
      write_csr(cfpf_pkg::CSR_IMAGE_WIDTH, 14'd16383);
      write_csr(cfpf_pkg::CSR_IMAGE_HEIGHT, 14'd0);
      send_item(make_point(10 << 16, 0, 0));
      wait_idle();
      write_csr(cfpf_pkg::CSR_IMAGE_HEIGHT, 14'd8192);

      // zero projective depth
      load_coefs(COEFS_FLAT_W);
      send_item(make_point(10 << 16, 0, 0));
      wait_idle();

      // random phases, each with its own table and register setting
      for (int ph = 0; ph < 9; ph++) begin
         write_csr(cfpf_pkg::CSR_FOV_ENABLE,
                   (ph == 1) ? 14'd0 : 14'(($urandom_range(0, 4) != 0)
                                           | ($urandom & 14'h3FFE)));
         write_csr(cfpf_pkg::CSR_IMAGE_WIDTH,  (ph < 2) ? 14'd1242 : pick_size());
         write_csr(cfpf_pkg::CSR_IMAGE_HEIGHT, (ph < 2) ? 14'd375  : pick_size());
         case (ph % 4)
            0: load_coefs(COEFS_PINHOLE);
            1: load_coefs(COEFS_MIRRORED);
            2: load_coefs($urandom_range(0, 1) ? COEFS_PINHOLE : COEFS_RANDOM);
            default: load_coefs(coef_set_type'($urandom_range(0, 3)));
         endcase
         no_gaps = (ph % 3 == 2);
         // flood the block while the receiver is held off
         if (ph == 3) hold_cycles = 120;
         n = 41;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
               0: r = make_point($urandom, $urandom, $urandom);
               1: begin
                  r = random_fields();
                  r.mode = cfpf_pkg::MODE_COEF;
                  r.coef_index = 5'($urandom_range(24, 31));
               end
               2: begin
                  // rewrite an entry with its own value, table stays consistent
                  r = random_fields();
                  r.mode = cfpf_pkg::MODE_COEF;
                  r.coef_index = 5'($urandom_range(0, cfpf_pkg::CoefCount - 1));
                  r.coef_value = sb.coef_table[r.coef_index];
               end
               default: r = scene_point();
            endcase
            send_item(r);
            if (i == 35 && $urandom_range(0, 1)) no_gaps = !no_gaps;
         end
         no_gaps = 1'b0;
         wait_idle();
      end

      // final drain, bounded
      n = 0;
      while (sb.kept_points.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (sb.kept_points.size() != 0)
         sb.report_mismatch($sformatf("%0d kept points never arrived",
                                      sb.kept_points.size()));
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/cfpf_pkg.sv
design/camera_frustum_point_filter.sv
bench/camera_frustum_point_filter_tb.sv
